// ===== rtl/rbc_pkg.sv =====
// ============================================================================
// rbc_pkg: shared types and helpers of the radix base converter
// Item structs, sequencer states, register indexes, ASCII digit constants
// and the digit/character mapping functions.
// ============================================================================
`default_nettype none

package rbc_pkg;

  // Default sizing handed to the top level
  localparam int DEF_VALUE_BITS = 32;
  localparam int DEF_MAX_DIGITS = 32;

  // ASCII digit characters
  localparam logic [7:0] CHAR_ZERO = 8'h30;  // '0'
  localparam logic [7:0] CHAR_NINE = 8'h39;  // '9'
  localparam logic [7:0] CHAR_A    = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_Z    = 8'h7a;  // 'z'
  localparam logic [7:0] CHAR_NONE = 8'h00;  // char field of an error item

  localparam logic [5:0] DIGIT_TEN     = 6'd10;
  localparam logic [5:0] DIGIT_INVALID = 6'd63;

  localparam logic [5:0] BASE_MIN = 6'd2;
  localparam logic [5:0] BASE_MAX = 6'd36;

  localparam logic [5:0] RST_INPUT_BASE  = 6'd10;
  localparam logic [5:0] RST_OUTPUT_BASE = 6'd2;

  // Register indexes (byte address / 4)
  localparam logic REG_INPUT_BASE  = 1'b0;
  localparam logic REG_OUTPUT_BASE = 1'b1;

  typedef struct packed {
    logic [7:0] in_char;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_last;
    logic       out_error;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_DIV,
    S_STORE,
    S_RD,
    S_LOAD,
    S_ERR
  } state_t;

  function automatic logic [5:0] clamp_base(logic [5:0] b);
    if (b < BASE_MIN) return BASE_MIN;
    if (b > BASE_MAX) return BASE_MAX;
    return b;
  endfunction

  // Digit value of a character, DIGIT_INVALID for anything else
  function automatic logic [5:0] digit_of(logic [7:0] c);
    if (c >= CHAR_ZERO && c <= CHAR_NINE) return 6'(c - CHAR_ZERO);
    if (c >= CHAR_A && c <= CHAR_Z) return 6'(c - CHAR_A) + DIGIT_TEN;
    return DIGIT_INVALID;
  endfunction

  function automatic logic [7:0] char_of(logic [5:0] r);
    if (r < DIGIT_TEN) return CHAR_ZERO + 8'(r);
    return CHAR_A + 8'(r - DIGIT_TEN);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/radix_base_converter.sv =====
// ============================================================================
// radix_base_converter: ASCII number conversion between two radixes
// Horner accumulation of input digits and repeated division by the output
// base, both on one shared add/subtract unit; digits are emitted MSB first.
// ============================================================================
//
// Feed a number as lower-case ASCII digits in base input_base, most
// significant first, with in_last on the final character. Each character
// is accepted, then goes through six shift-add steps of the multiply by
// the input base and one step to add the digit. The last character then
// starts the conversion: every output digit takes one restoring-division
// step per value bit plus a store into the remainder memory, and every
// emitted digit then takes a memory read and an output load, which waits
// while the output register is full. All multiply, add and divide steps
// go through one add/subtract unit. in_ready is high only while the
// sequencer is idle; the final result item may still sit in the output
// register while the next number is taken. An invalid character,
// an overflow of VALUE_BITS bits, or a conversion needing more than
// MAX_DIGITS digits yields one item with out_error and out_last set and
// out_char zero. Bases outside 2..36 are clamped. Write the base registers
// (byte address 0 and 4) only while the block is idle.
`default_nettype none

module radix_base_converter #(
  parameter int VALUE_BITS = rbc_pkg::DEF_VALUE_BITS,
  parameter int MAX_DIGITS = rbc_pkg::DEF_MAX_DIGITS
) (
  input  wire                  clk,
  input  wire                  rst_n,
  // input item channel
  input  wire                  in_valid,
  output logic                 in_ready,
  input  rbc_pkg::in_item_t    in_data,
  // result item channel
  output logic                 out_valid,
  input  wire                  out_ready,
  output rbc_pkg::out_item_t   out_data,
  // configuration port
  input  wire                  psel,
  input  wire                  penable,
  input  wire                  pwrite,
  input  wire  [2:0]           paddr,
  input  wire  [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import rbc_pkg::*;

  localparam int W  = VALUE_BITS + 6;            // product width of value * base
  localparam int AW = $clog2(MAX_DIGITS);        // remainder memory address
  localparam int CW = $clog2(MAX_DIGITS + 1);    // digit count
  localparam int SW = $clog2(VALUE_BITS);        // step counter

  // ---------------------------------------------------------------- config
  logic [5:0] ib_r, ob_r;
  logic [5:0] ib_c, ob_c;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign ib_c   = clamp_base(ib_r);
  assign ob_c   = clamp_base(ob_r);

  always_comb begin
    case (paddr[2])
      REG_INPUT_BASE:  prdata = {26'b0, ib_r};
      REG_OUTPUT_BASE: prdata = {26'b0, ob_r};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ib_r <= RST_INPUT_BASE;
      ob_r <= RST_OUTPUT_BASE;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_INPUT_BASE:  ib_r <= pwdata[5:0];
        REG_OUTPUT_BASE: ob_r <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------- registers
  state_t              state_r, state_nxt;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt;     // accumulated value
  logic                err_r, err_nxt;       // error seen in this number
  logic [CW-1:0]       cnt_r, cnt_nxt;       // digits stored
  logic [W-1:0]        prod_r, prod_nxt;     // multiply partial product
  logic [5:0]          mulsh_r, mulsh_nxt;   // input base, MSB-first
  logic [VALUE_BITS-1:0] q_r, q_nxt;         // dividend / quotient
  logic [5:0]          rem_r, rem_nxt;       // partial remainder
  logic [SW-1:0]       step_r, step_nxt;
  logic [5:0]          dig_r, dig_nxt;       // digit of the held item
  logic                last_r, last_nxt;
  logic [AW-1:0]       idx_r, idx_nxt;       // emit read pointer
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;
  logic [5:0]          rd_data_r;

  logic       in_fire;
  logic       out_free;
  logic [5:0] in_dig;
  logic       in_bad;
  logic       mem_we;
  logic [6:0] div_t;
  logic       ovf;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign in_dig    = digit_of(in_data.in_char);
  assign in_bad    = (in_dig >= ib_c);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign div_t     = {rem_r, q_r[VALUE_BITS-1]};

  // ------------------------------------------------- shared add/sub unit
  logic [W-1:0] alu_a, alu_b;
  logic         alu_sub;
  logic [W:0]   alu_sum;
  logic         alu_carry;

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_r)
      S_MUL: begin
        alu_a = {prod_r[W-2:0], 1'b0};
        alu_b = mulsh_r[5] ? W'(acc_r) : '0;
      end
      S_ADD: begin
        alu_a = prod_r;
        alu_b = W'(dig_r);
      end
      S_DIV: begin
        alu_a   = W'(div_t);
        alu_b   = W'(ob_c);
        alu_sub = 1'b1;
      end
      default: ;
    endcase
  end

  assign alu_sum   = {1'b0, alu_a} + {1'b0, alu_b ^ {W{alu_sub}}} + (W+1)'(alu_sub);
  assign alu_carry = alu_sum[W];
  assign ovf       = |alu_sum[W-1:VALUE_BITS];

  // ------------------------------------------------------------ next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (err_r || in_bad) state_nxt = in_data.in_last ? S_ERR : S_IDLE;
          else                 state_nxt = S_MUL;
        end
      end
      S_MUL:   if (step_r == SW'(5)) state_nxt = S_ADD;
      S_ADD: begin
        if (!last_r)  state_nxt = S_IDLE;
        else if (ovf) state_nxt = S_ERR;
        else          state_nxt = S_DIV;
      end
      S_DIV:   if (step_r == SW'(VALUE_BITS - 1)) state_nxt = S_STORE;
      S_STORE: begin
        if (q_r == '0)                          state_nxt = S_RD;
        else if (cnt_r == CW'(MAX_DIGITS - 1))  state_nxt = S_ERR;
        else                                    state_nxt = S_DIV;
      end
      S_RD:    state_nxt = S_LOAD;
      S_LOAD:  if (out_free) state_nxt = (idx_r == '0) ? S_IDLE : S_RD;
      S_ERR:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // ------------------------------------------------------- datapath/outputs
  always_comb begin
    acc_nxt       = acc_r;
    err_nxt       = err_r;
    cnt_nxt       = cnt_r;
    prod_nxt      = prod_r;
    mulsh_nxt     = mulsh_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    dig_nxt       = dig_r;
    last_nxt      = last_r;
    idx_nxt       = idx_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mem_we        = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          last_nxt  = in_data.in_last;
          dig_nxt   = in_dig;
          prod_nxt  = '0;
          mulsh_nxt = ib_c;
          step_nxt  = '0;
          if (!err_r && in_bad) err_nxt = 1'b1;
        end
      end
      S_MUL: begin
        prod_nxt  = alu_sum[W-1:0];
        mulsh_nxt = {mulsh_r[4:0], 1'b0};
        step_nxt  = step_r + SW'(1);
      end
      S_ADD: begin
        if (ovf) begin
          err_nxt = 1'b1;
        end else begin
          acc_nxt = alu_sum[VALUE_BITS-1:0];
          // start the first division on the final value
          q_nxt    = alu_sum[VALUE_BITS-1:0];
          rem_nxt  = '0;
          step_nxt = '0;
          cnt_nxt  = '0;
        end
      end
      S_DIV: begin
        rem_nxt  = alu_carry ? alu_sum[5:0] : div_t[5:0];
        q_nxt    = {q_r[VALUE_BITS-2:0], alu_carry};
        step_nxt = step_r + SW'(1);
      end
      S_STORE: begin
        mem_we   = 1'b1;
        cnt_nxt  = cnt_r + CW'(1);
        idx_nxt  = cnt_r[AW-1:0];
        rem_nxt  = '0;
        step_nxt = '0;
        if (q_r != '0 && cnt_r == CW'(MAX_DIGITS - 1)) err_nxt = 1'b1;
      end
      S_LOAD: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.out_char  = char_of(rd_data_r);
          out_data_nxt.out_last  = (idx_r == '0);
          out_data_nxt.out_error = 1'b0;
          idx_nxt                = idx_r - AW'(1);
          if (idx_r == '0) begin
            acc_nxt = '0;
            err_nxt = 1'b0;
            cnt_nxt = '0;
          end
        end
      end
      S_ERR: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.out_char  = CHAR_NONE;
          out_data_nxt.out_last  = 1'b1;
          out_data_nxt.out_error = 1'b1;
          acc_nxt                = '0;
          err_nxt                = 1'b0;
          cnt_nxt                = '0;
        end
      end
      default: ;
    endcase
  end

  // ------------------------------------------------------ remainder memory
  logic [5:0] rem_mem [MAX_DIGITS];

  always_ff @(posedge clk) begin
    if (mem_we) rem_mem[cnt_r[AW-1:0]] <= rem_r;
    rd_data_r <= rem_mem[idx_r];
  end

  // ---------------------------------------------------------- state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      acc_r       <= '0;
      err_r       <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      err_r       <= err_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r     <= prod_nxt;
    mulsh_r    <= mulsh_nxt;
    q_r        <= q_nxt;
    rem_r      <= rem_nxt;
    step_r     <= step_nxt;
    dig_r      <= dig_nxt;
    last_r     <= last_nxt;
    idx_r      <= idx_nxt;
    out_data_r <= out_data_nxt;
  end

  // ------------------------------------------------------------ assertions
  a_store_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_STORE |-> cnt_r < CW'(MAX_DIGITS))
    else $error("digit store beyond remainder memory");

  a_rem_below_base: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_STORE |-> rem_r < ob_c)
    else $error("remainder not below output base");

  a_emit_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD || state_r == S_LOAD) |-> CW'(idx_r) < cnt_r)
    else $error("emit pointer past stored digits");

  a_err_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.out_error |->
      out_data_r.out_last && out_data_r.out_char == CHAR_NONE)
    else $error("malformed error item");

  a_load_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD || state_r == S_ERR) && out_valid_r && !out_ready |=>
      $stable(out_data_r))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

// ===== tb/tb_radix_base_converter.sv =====
// ============================================================================
// tb_radix_base_converter: self-checking bench of the radix base converter
// Streams ASCII numbers through the input channel under several base
// settings and compares every emitted digit item with a Horner/division
// predictor kept in step with each accepted item.
// ============================================================================
`default_nettype none

module tb_radix_base_converter;
  timeunit 1ns;
  timeprecision 1ps;

  import rbc_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 11;
  localparam int MAX_GAP       = 12;
  localparam int HOLD_CYCLES   = 300;       // long sink stall for the fill-up test
  localparam int SETTLE_CYCLES = 40;        // covers one character's multiply-add plus margin
  localparam int DRAIN_CYCLES  = 80;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int TOTAL_CHARS   = 180;
  localparam int TAIL_CHARS    = 40;        // reserved for the pressure tests
  localparam int PHASE_CHARS   = 25;
  localparam int NUM_DIGITS    = DEF_MAX_DIGITS;
  localparam longint unsigned VALUE_MASK = (64'd1 << DEF_VALUE_BITS) - 64'd1;

  // --------------------------------------------------------------------------
  // DUT signals, all inputs driven to known values from time zero
  // --------------------------------------------------------------------------
  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  // --------------------------------------------------------------------------
  // Bench state: predictor copy of the registers and the number in flight,
  // the queue of digit items still owed by the block, and run bookkeeping
  // --------------------------------------------------------------------------
  logic [5:0]      in_radix_reg;
  logic [5:0]      out_radix_reg;
  longint unsigned horner_value;
  bit              number_bad;
  out_item_t       owed_digits[$];

  int unsigned chars_sent   = 0;
  int unsigned digits_seen  = 0;
  int unsigned mismatches   = 0;
  int unsigned cycle_count  = 0;
  bit          no_gaps      = 1'b0;   // both sides run without idle cycles
  bit          hold_request = 1'b0;   // ask the sink for one long stall

  radix_base_converter i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #CLK_HALF clk = ~clk;

  // Kill the run if it hangs, e.g. when an owed digit never shows up
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Predictor helpers
  // --------------------------------------------------------------------------

  // Register values outside 2..36 act as the nearest legal base
  function automatic int unsigned eff_radix(logic [5:0] b);
    if (b < BASE_MIN) return BASE_MIN;
    if (b > BASE_MAX) return BASE_MAX;
    return b;
  endfunction

  function automatic int unsigned digit_value(logic [7:0] c);
    if (c >= CHAR_ZERO && c <= CHAR_NINE) return c - CHAR_ZERO;
    if (c >= CHAR_A && c <= CHAR_Z) return c - CHAR_A + DIGIT_TEN;
    return DIGIT_INVALID;
  endfunction

  function automatic logic [7:0] digit_char(int unsigned d);
    if (d < DIGIT_TEN) return CHAR_ZERO + 8'(d);
    return CHAR_A + 8'(d - DIGIT_TEN);
  endfunction

  // Digits needed for the largest representable value in base b
  function automatic int unsigned full_width_len(int unsigned b);
    longint unsigned v;
    int unsigned n;
    v = VALUE_MASK;
    n = 0;
    while (v != 0) begin
      v = v / b;
      n++;
    end
    return n;
  endfunction

  // Fold one accepted character into the running number; on the last one,
  // queue the digit items the block owes (or its single error item)
  task automatic fold_char(in_item_t it);
    int unsigned ib;
    int unsigned ob;
    int unsigned d;
    int unsigned n;
    longint unsigned v;
    int unsigned rem[NUM_DIGITS];
    out_item_t r;
    ib = eff_radix(in_radix_reg);
    ob = eff_radix(out_radix_reg);
    // Once a number went bad, drop the rest of its characters
    if (!number_bad) begin
      d = digit_value(it.in_char);
      if (d >= ib) number_bad = 1'b1;
      else if (horner_value > (VALUE_MASK - d) / ib) number_bad = 1'b1;
      else horner_value = horner_value * ib + d;
    end
    if (!it.in_last) return;
    n = 0;
    if (!number_bad) begin
      v = horner_value;
      do begin
        if (n >= NUM_DIGITS) begin
          number_bad = 1'b1;
          break;
        end
        rem[n] = 32'(v % ob);
        n++;
        v = v / ob;
      end while (v != 0);
    end
    if (number_bad) begin
      r.out_char  = CHAR_NONE;
      r.out_last  = 1'b1;
      r.out_error = 1'b1;
      owed_digits.push_back(r);
    end else begin
      // Remainders come out least significant first; emit them reversed
      for (int k = n - 1; k >= 0; k--) begin
        r.out_char  = digit_char(rem[k]);
        r.out_last  = (k == 0);
        r.out_error = 1'b0;
        owed_digits.push_back(r);
      end
    end
    horner_value = 0;
    number_bad   = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------

  // Offer one character after a random gap; valid stays high between
  // back-to-back items so it is never dropped and raised in one step
  task automatic send_char(logic [7:0] c, logic last);
    int unsigned gap;
    in_item_t it;
    it.in_char = c;
    it.in_last = last;
    gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    fold_char(it);
    chars_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // Drop valid, wait for every owed digit, then let the sequencer go idle
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (owed_digits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; junk in the upper data bits must not
  // leak into the 6-bit register
  task automatic write_base(logic idx, logic [5:0] val);
    logic [31:0] word;
    word      = $urandom;
    word[5:0] = val;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_INPUT_BASE) in_radix_reg = val;
    else out_radix_reg = val;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_bases(logic [5:0] ib, logic [5:0] ob);
    settle();
    write_base(REG_INPUT_BASE, ib);
    write_base(REG_OUTPUT_BASE, ob);
  endtask

  // Mostly short well-formed numbers, some near the value width (so some
  // overflow), and some with one random byte planted somewhere
  task automatic send_random_number();
    int unsigned ib;
    int unsigned kind;
    int unsigned len;
    int unsigned bad_pos;
    logic [7:0] c;
    ib   = eff_radix(in_radix_reg);
    kind = $urandom_range(0, 9);
    if (kind < 6) len = $urandom_range(1, 6);
    else if (kind < 8) len = full_width_len(ib) + $urandom_range(0, 1);
    else len = $urandom_range(1, 6);
    bad_pos = (kind >= 8) ? $urandom_range(0, len - 1) : len;
    for (int unsigned i = 0; i < len; i++) begin
      if (i == bad_pos) c = 8'($urandom_range(0, 255));
      else c = digit_char($urandom_range(0, ib - 1));
      send_char(c, i == len - 1);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random sink stalls, one long hold on request
  // --------------------------------------------------------------------------
  always begin : result_sink
    int unsigned stall;
    stall = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
    if (hold_request) begin
      stall        = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    @(negedge clk);
    if (stall != 0) begin
      out_ready <= 1'b0;
      repeat (stall) @(negedge clk);
    end
    out_ready <= 1'b1;
    do @(posedge clk); while (!(out_valid && rst_n));
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on digit item %0d: %s got 0x%0h, want 0x%0h",
             digits_seen, what, got, want);
    mismatches++;
  endtask

  // Compare each accepted digit item with the oldest owed one
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (owed_digits.size() == 0) begin
        report_mismatch("unexpected item, char", out_data.out_char, 0);
      end else begin
        want = owed_digits.pop_front();
        if (out_data.out_char !== want.out_char)
          report_mismatch("out_char", out_data.out_char, want.out_char);
        if (out_data.out_last !== want.out_last)
          report_mismatch("out_last", out_data.out_last, want.out_last);
        if (out_data.out_error !== want.out_error)
          report_mismatch("out_error", out_data.out_error, want.out_error);
      end
      digits_seen++;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset bases, decimal to binary: zero, then the largest value (32 digits)
  task automatic test_default_bases();
    send_text("0");
    send_text("4294967295");
  endtask

  // Digit at the base, a non-digit followed by an ignored digit, top byte
  task automatic test_invalid_digits();
    send_text("a");
    send_text("/5");
    send_char(8'hff, 1'b1);
  endtask

  // Widest bases: overflow by one past the maximum, then the top digit
  task automatic test_wide_bases();
    set_bases(BASE_MAX, BASE_MAX);
    send_text("1z141z4");
    send_text("z");
  endtask

  // Register values below 2 and above 36 act as 2 and 36
  task automatic test_clamped_bases();
    set_bases(6'd1, 6'd63);
    send_text("10");
    send_text("2");
  endtask

  // Random numbers over a series of base settings, extremes first
  task automatic test_random_numbers();
    int unsigned phase;
    int unsigned phase_start;
    phase = 0;
    while (chars_sent < TOTAL_CHARS - TAIL_CHARS) begin
      case (phase)
        0: set_bases(BASE_MIN, BASE_MAX);
        1: set_bases(BASE_MAX, BASE_MIN);
        2: set_bases(6'd16, 6'd10);
        default: set_bases(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
      endcase
      phase_start = chars_sent;
      while (chars_sent - phase_start < PHASE_CHARS &&
             chars_sent < TOTAL_CHARS - TAIL_CHARS)
        send_random_number();
      phase++;
    end
  endtask

  // Hold the sink in the middle of an eight-digit result while numbers keep
  // coming, so the block backs up and stalls its input; then pause until
  // all owed digits are out
  task automatic test_sink_hold();
    set_bases(6'd10, 6'd16);
    hold_request = 1'b1;
    send_text("4294967295");
    repeat (3) send_random_number();
    settle();
  endtask

  // No idle cycles on either side
  task automatic test_back_to_back();
    set_bases(6'd8, 6'd3);
    no_gaps = 1'b1;
    repeat (4) send_random_number();
    settle();
    no_gaps = 1'b0;
  endtask

  initial begin
    in_radix_reg  = RST_INPUT_BASE;
    out_radix_reg = RST_OUTPUT_BASE;
    horner_value  = 0;
    number_bad    = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_default_bases();
    test_invalid_digits();
    test_wide_bases();
    test_clamped_bases();
    test_random_numbers();
    test_sink_hold();
    test_back_to_back();

    // Drain, then watch a while longer for stray items
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== radix_base_converter.f =====
rtl/rbc_pkg.sv
rtl/radix_base_converter.sv
tb/tb_radix_base_converter.sv
